// File: rtl/cops_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cops_pkg
// Types, register indexes and shared helpers of the clock offset PI servo.
// ----------------------------------------------------------------------------
package cops_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 63;

  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SUM_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ONES64  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ONES32  = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATS_ALPHA    = 3'd0,
    REG_RATE_BASIS     = 3'd1,
    REG_RATE_MIN       = 3'd2,
    REG_RATE_MAX       = 3'd3,
    REG_INTEGRAL_RATE  = 3'd4,
    REG_MAX_TRIM       = 3'd5,
    REG_STEP_THRESHOLD = 3'd6
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_SQM, S_SQD, S_EV0, S_EV1, S_ES1, S_EO1,
    S_SQV, S_SQS, S_RATE, S_DIV, S_PM0, S_PM1, S_PM2, S_INT,
    S_TRIM, S_OUT, S_SC0, S_SC1, S_SC2
  } state_t;

  function automatic logic [63:0] abs_diff(input logic [63:0] x, input logic [63:0] v);
    return (x >= v) ? (x - v) : (v - x);
  endfunction

  // gain clamp: max first, min last so it wins on crossed limits
  function automatic logic [31:0] rate_clamp(input logic over, input logic [31:0] q,
                                             input logic [31:0] mx, input logic [31:0] mn);
    logic [31:0] r;
    r = (over || (q > mx)) ? mx : q;
    if (r < mn) r = mn;
    return r;
  endfunction

  function automatic logic signed [63:0] sat_sym(input logic signed [63:0] v,
                                                 input logic signed [63:0] lim);
    logic signed [63:0] r;
    r = v;
    if (v > lim) r = lim;
    if (v < -lim) r = -lim;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/clock_offset_pi_servo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_offset_pi_servo
// PI clock servo: step detection, offset statistics, RMS-scaled gain, saturated trim.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  input   | in_valid, in_stall, offset           | in (stall out)
//  result  | out_valid, out_stall, action ... int | out (stall in)
//  config  | wr_en, wr_index, wr_data             | in
//
//  A step offset goes from accept straight to the result; a first sample skips
//  the square roots and a tracking sample runs them. Tracking time is set by two
//  32-step square roots and the 32-step divider around one shared 32x32
//  multiplier; the divide is skipped when the gain saturates at rate_max.
//  in_stall is high from accept until the result is loaded into the output
//  register; a held output stalls only the final load.
//  Synchronous reset restores register defaults and clears the statistics.
// ----------------------------------------------------------------------------
module clock_offset_pi_servo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [cops_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [cops_pkg::CFG_DATA_W-1:0] wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [63:0]              offset,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            action,
  output logic signed [63:0]              step_adjust,
  output logic signed [31:0]              freq_trim,
  output logic signed [63:0]              mean,
  output logic [31:0]                     std_dev,
  output logic [31:0]                     rms,
  output logic signed [63:0]              proportional,
  output logic signed [63:0]              integral
);
  import cops_pkg::*;

  // configuration
  logic [15:0] stats_alpha;
  logic [31:0] rate_basis;
  logic [31:0] rate_min;
  logic [31:0] rate_max;
  logic [15:0] integral_rate;
  logic [30:0] max_trim;
  logic [62:0] step_threshold;

  // servo state
  logic signed [63:0] avg_offset;
  logic [63:0]        avg_variance;
  logic [63:0]        avg_square;
  logic signed [63:0] integral_acc;

  // work registers
  state_t             state, state_next, ret;
  logic signed [63:0] off;
  logic [63:0]        mag;
  logic               neg;
  logic               up;
  logic               dir;
  logic               is_step;
  logic [63:0]        dmag, sqm, sqd, sd, sres, pm, prod_lo;
  logic [15:0]        sa;
  logic [47:0]        part_lo;
  logic [31:0]        std_q, rms_q, rate;
  logic signed [31:0] freq_q;
  logic signed [63:0] prop_q;

  // shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        sq_start, sq_done;
  logic [63:0] sq_x;
  logic [31:0] sq_root;
  logic        div_start, div_done;
  logic [31:0] div_quo;

  cops_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  cops_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x_in(sq_x), .done(sq_done), .root(sq_root)
  );

  cops_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .hi(rms_q), .den(rate_basis),
    .done(div_done), .quo(div_quo)
  );

  // datapath helpers
  logic               step_hit, up_w, rate_over, out_free;
  logic [63:0]        dmag_w, sqm_w, sqd_w, pm_sum, pm_w, dm_w, pc_w;
  logic [79:0]        sum80;
  logic [31:0]        first_q, tm_w;
  logic signed [63:0] lim_w, integ_w, trim_w, tmag_w;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign step_hit  = (mag >= {1'b0, step_threshold});
  assign up_w      = (off >= avg_offset);
  assign dmag_w    = up_w ? 64'(off - avg_offset) : 64'(avg_offset - off);
  assign sqm_w     = (|mag[63:32]) ? ONES64 : prod;
  assign sqd_w     = (|dmag[63:32]) ? ONES64 : prod;
  assign first_q   = (|mag[63:32]) ? ONES32 : mag[31:0];
  assign sum80     = {prod[47:0], 32'd0} + {32'd0, part_lo};
  assign rate_over = (rate_basis == 32'd0) || (rms_q >= rate_basis);
  assign pm_sum    = {1'b0, prod[46:0], 16'd0} + {16'd0, prod_lo[63:16]};
  assign pm_w      = ((|prod[63:47]) || pm_sum[63]) ? MAX_POS : pm_sum;
  assign lim_w     = $signed({17'd0, max_trim, 16'd0});
  assign dm_w      = (sres > SUM_CAP) ? SUM_CAP : sres;
  assign integ_w   = sat_sym(integral_acc + (neg ? -$signed(dm_w) : $signed(dm_w)), lim_w);
  assign pc_w      = (pm > SUM_CAP) ? SUM_CAP : pm;
  assign trim_w    = sat_sym((neg ? -$signed(pc_w) : $signed(pc_w)) + integral_acc, lim_w);
  assign tmag_w    = trim_w[63] ? -trim_w : trim_w;
  assign tm_w      = tmag_w[47:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = 32'd0;
    mul_b      = 32'd0;
    sq_start   = 1'b0;
    sq_x       = avg_variance;
    div_start  = 1'b0;
    case (state)
      S_IDLE: if (in_valid) state_next = S_CHK;
      S_CHK: begin
        mul_a      = mag[31:0];
        mul_b      = mag[31:0];
        state_next = step_hit ? S_OUT : S_SQM;
      end
      S_SQM: begin
        mul_a      = dmag[31:0];
        mul_b      = dmag[31:0];
        state_next = (avg_square == 64'd0) ? S_RATE : S_SQD;
      end
      S_SQD: state_next = S_EV0;
      S_EV0, S_EV1, S_ES1: state_next = S_SC0;
      S_SC0: begin
        mul_a      = sd[31:0];
        mul_b      = {16'd0, sa};
        state_next = S_SC1;
      end
      S_SC1: begin
        mul_a      = sd[63:32];
        mul_b      = {16'd0, sa};
        state_next = S_SC2;
      end
      S_SC2: state_next = ret;
      S_EO1: begin
        sq_start   = 1'b1;
        state_next = S_SQV;
      end
      S_SQV: begin
        if (sq_done) begin
          sq_start   = 1'b1;
          sq_x       = avg_square;
          state_next = S_SQS;
        end
      end
      S_SQS: if (sq_done) state_next = S_RATE;
      S_RATE: begin
        div_start  = !rate_over;
        state_next = rate_over ? S_PM0 : S_DIV;
      end
      S_DIV: if (div_done) state_next = S_PM0;
      S_PM0: begin
        mul_a      = mag[31:0];
        mul_b      = rate;
        state_next = S_PM1;
      end
      S_PM1: begin
        mul_a      = mag[63:32];
        mul_b      = rate;
        state_next = S_PM2;
      end
      S_PM2: state_next = S_SC0;
      S_INT: state_next = S_TRIM;
      S_TRIM: state_next = S_OUT;
      S_OUT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stats_alpha    <= 16'd4096;
      rate_basis     <= 32'd42950;
      rate_min       <= 32'd42949673;
      rate_max       <= 32'd2147483648;
      integral_rate  <= 16'd6554;
      max_trim       <= 31'd4295;
      step_threshold <= 63'd42949673;
    end else if (wr_en) begin
      case (wr_index)
        REG_STATS_ALPHA:    stats_alpha    <= wr_data[15:0];
        REG_RATE_BASIS:     rate_basis     <= wr_data[31:0];
        REG_RATE_MIN:       rate_min       <= wr_data[31:0];
        REG_RATE_MAX:       rate_max       <= wr_data[31:0];
        REG_INTEGRAL_RATE:  integral_rate  <= wr_data[15:0];
        REG_MAX_TRIM:       max_trim       <= wr_data[30:0];
        REG_STEP_THRESHOLD: step_threshold <= wr_data;
        default: ;
      endcase
    end
  end

  // servo state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_offset   <= '0;
      avg_variance <= '0;
      avg_square   <= '0;
      integral_acc <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CHK: begin
          if (step_hit) begin
            avg_offset   <= '0;
            avg_variance <= '0;
            avg_square   <= '0;
          end
        end
        S_SQM: begin
          if (avg_square == 64'd0) begin
            avg_offset   <= off;
            avg_variance <= sqm_w;
            avg_square   <= sqm_w;
          end
        end
        S_EV1: avg_variance <= dir ? avg_variance + sres : avg_variance - sres;
        S_ES1: avg_square   <= dir ? avg_square + sres : avg_square - sres;
        S_EO1: avg_offset   <= up ? $signed(64'(avg_offset + sres))
                                  : $signed(64'(avg_offset - sres));
        S_INT: integral_acc <= integ_w;
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        off <= offset;
        mag <= offset[63] ? 64'(-offset) : 64'(offset);
        neg <= offset[63];
      end
      S_CHK: begin
        is_step <= step_hit;
        up      <= up_w;
        dmag    <= dmag_w;
      end
      S_SQM: begin
        sqm   <= sqm_w;
        rms_q <= first_q;
        std_q <= first_q;
      end
      S_SQD: sqd <= sqd_w;
      S_EV0: begin
        dir <= (sqd >= avg_variance);
        sd  <= abs_diff(sqd, avg_variance);
        sa  <= stats_alpha;
        ret <= S_EV1;
      end
      S_EV1: begin
        dir <= (sqm >= avg_square);
        sd  <= abs_diff(sqm, avg_square);
        ret <= S_ES1;
      end
      S_ES1: begin
        sd  <= dmag;
        ret <= S_EO1;
      end
      S_SC1: part_lo <= prod[47:0];
      S_SC2: sres    <= sum80[79:16];
      S_SQV: if (sq_done) std_q <= sq_root;
      S_SQS: if (sq_done) rms_q <= sq_root;
      S_RATE: if (rate_over) rate <= rate_clamp(1'b1, 32'd0, rate_max, rate_min);
      S_DIV: if (div_done) rate <= rate_clamp(1'b0, div_quo, rate_max, rate_min);
      S_PM1: prod_lo <= prod;
      S_PM2: begin
        pm  <= pm_w;
        sd  <= pm_w;
        sa  <= integral_rate;
        ret <= S_INT;
      end
      S_TRIM: begin
        freq_q <= trim_w[63] ? -$signed(tm_w) : $signed(tm_w);
        prop_q <= neg ? -$signed(pm) : $signed(pm);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      action       <= is_step;
      step_adjust  <= is_step ? off : '0;
      freq_trim    <= is_step ? '0 : freq_q;
      mean         <= is_step ? '0 : avg_offset;
      std_dev      <= is_step ? '0 : std_q;
      rms          <= is_step ? '0 : rms_q;
      proportional <= is_step ? '0 : prop_q;
      integral     <= integral_acc;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cops_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cops_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module cops_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= {32'd0, a} * {32'd0, b};
  end

endmodule
`default_nettype wire

// File: rtl/cops_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cops_sqrt
// Bit-serial integer square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
module cops_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x_in,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] x;
  logic [63:0] r;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      busy <= (bitv != 64'd1);
      done <= (bitv == 64'd1);
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= x_in;
      r    <= 64'd0;
      bitv <= 64'd1 << 62;
    end else if (busy) begin
      if (x >= trial) begin
        x <= x - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cops_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cops_div
// Restoring divider: (hi << 32) / den, for hi < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cops_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] hi,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);

  logic [31:0] rem;
  logic [31:0] dsr;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem, 1'b0};
  assign fits    = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      busy <= (cnt != 5'd0);
      done <= (cnt == 5'd0);
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= hi;
      dsr <= den;
      cnt <= 5'd31;
    end else if (busy) begin
      rem <= fits ? 32'(shifted - {1'b0, dsr}) : shifted[31:0];
      quo <= {quo[30:0], fits};
      cnt <= cnt - 5'd1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cops_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cops_checker
// Port-level checks on the servo, bound to the top level.
// ----------------------------------------------------------------------------
module cops_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            action,
  input logic signed [63:0]              step_adjust,
  input logic signed [31:0]              freq_trim,
  input logic signed [63:0]              mean,
  input logic [31:0]                     std_dev,
  input logic [31:0]                     rms,
  input logic signed [63:0]              proportional,
  input logic signed [63:0]              integral
);

  // reset leaves no result pending and the input open
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("result or busy after reset");

  // an accepted offset keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transaction");

  a_step_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && action |-> freq_trim == 0 && rms == 0 && std_dev == 0 &&
                            proportional == 0 && mean == 0)
    else $error("step result carries servo values");

  a_trim_no_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !action |-> step_adjust == 0)
    else $error("trim result carries a step amount");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(action) && $stable(freq_trim) &&
                               $stable(step_adjust) && $stable(integral))
    else $error("stalled result changed");

endmodule

bind clock_offset_pi_servo cops_checker u_cops_checker (.*);
`default_nettype wire
